/* rtl/core/wildcard_byte_pattern_scanner_defines.svh */
// Assertion macros shared by the scanner RTL.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_DEFINES_SVH

// Same-cycle implication.
`define WBPS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define WBPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/wbps_pkg.sv */
// Shared types and constants for the wildcard byte pattern scanner.
// No dependencies; used by wbps_match and the top level.
`timescale 1ns / 1ps
package wbps_pkg;

	localparam int PATTERN_MAX = 32;
	localparam int IDX_W       = $clog2(PATTERN_MAX);
	localparam int BLOCK_BYTES = 65536;
	localparam int POS_W       = $clog2(BLOCK_BYTES + 1);
	localparam int ADDR_W      = 48;
	localparam int LEN_W       = 6;
	localparam int PWORDS      = 4;
	localparam int PWORD_W     = 64;
	localparam int WILD_W      = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;

	typedef logic [7:0]                  byte_t;
	typedef logic [PATTERN_MAX-1:0][7:0] window_t;
	typedef logic [POS_W-1:0]            pos_t;
	typedef logic [ADDR_W-1:0]           addr_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_0  = 3'd0,
		REG_PATTERN_1  = 3'd1,
		REG_PATTERN_2  = 3'd2,
		REG_PATTERN_3  = 3'd3,
		REG_WILDCARD   = 3'd4,
		REG_LENGTH     = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [PWORDS-1:0][PWORD_W-1:0] pattern;
		logic [WILD_W-1:0]              wild;
		logic [LEN_W-1:0]               length;
	} cfg_t;

endpackage

/* rtl/core/wbps_match.sv */
// Parallel compare unit: aligns the pattern to the window and checks every byte.
// Depends on wbps_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "wildcard_byte_pattern_scanner_defines.svh"
module wbps_match (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wbps_pkg::cfg_t       cfg,
	input  wbps_pkg::window_t    window,
	input  wbps_pkg::pos_t       pos,
	output logic                 hit,
	output wbps_pkg::pos_t       offset
);

	logic [wbps_pkg::PATTERN_MAX-1:0][7:0] pat_flat;
	logic [wbps_pkg::LEN_W-1:0]            len_eff;
	logic [wbps_pkg::LEN_W-1:0]            k;
	wbps_pkg::window_t                     pat_d;
	wbps_pkg::window_t                     pat_q;
	logic [wbps_pkg::PATTERN_MAX-1:0]      wild_d;
	logic [wbps_pkg::PATTERN_MAX-1:0]      wild_q;
	logic [wbps_pkg::LEN_W-1:0]            len_q;
	logic [wbps_pkg::PATTERN_MAX-1:0]      byte_ok;

	assign pat_flat = cfg.pattern;

	// Clamp the length into 1..PATTERN_MAX.
	always_comb begin
		priority if (cfg.length == '0) begin
			len_eff = wbps_pkg::LEN_W'(1);
		end else if (cfg.length > wbps_pkg::LEN_W'(wbps_pkg::PATTERN_MAX)) begin
			len_eff = wbps_pkg::LEN_W'(wbps_pkg::PATTERN_MAX);
		end else begin
			len_eff = cfg.length;
		end
	end

	// Window entry j (0 newest) lines up with pattern byte len-1-j; entries past
	// the length are don't-care.
	always_comb begin
		k = '0;
		for (int j = 0; j < wbps_pkg::PATTERN_MAX; j++) begin
			k = len_eff - wbps_pkg::LEN_W'(1) - wbps_pkg::LEN_W'(j);
			if (wbps_pkg::LEN_W'(j) < len_eff) begin
				pat_d[j]  = pat_flat[k[wbps_pkg::IDX_W-1:0]];
				wild_d[j] = cfg.wild[k[wbps_pkg::IDX_W-1:0]];
			end else begin
				pat_d[j]  = '0;
				wild_d[j] = 1'b1;
			end
		end
	end

	// Aligned pattern only changes with configuration.
	always_ff @(posedge clk) begin
		pat_q  <= pat_d;
		wild_q <= wild_d;
		len_q  <= len_eff;
	end

	always_comb begin
		for (int j = 0; j < wbps_pkg::PATTERN_MAX; j++) begin
			byte_ok[j] = wild_q[j] || (window[j] == pat_q[j]);
		end
	end

	assign hit    = (pos >= wbps_pkg::POS_W'(len_q)) && (&byte_ok);
	assign offset = pos - wbps_pkg::POS_W'(len_q);

	`WBPS_ASSERT_NOW(a_hit_len, hit, (len_q != '0), "match with zero aligned length")
	`WBPS_ASSERT_NOW(a_len_range, (pos != '0),
		(len_q <= wbps_pkg::LEN_W'(wbps_pkg::PATTERN_MAX)), "aligned length beyond window")
	`WBPS_ASSERT_NOW(a_offset_range, hit, (offset < pos), "match offset not inside block")

endmodule

/* rtl/core/wildcard_byte_pattern_scanner.sv */
// Top level of the wildcard byte pattern scanner: config registers, window, handshakes.
// Depends on wbps_pkg, wbps_match and the assertion macros header.
//
//   channel  direction  handshake              word
//   in       sink       in_valid / in_ready    data_byte, block_start, block_address
//   out      source     out_valid / out_ready  match_address
//   cfg      sink       cfg_write              cfg_index, cfg_data
//
// One byte per cycle unless a match waits on an unaccepted result; out_valid rises after the
// matching byte passes the window register, feeding the parallel compare, and the result
// register, holding the address. A config write reaches the compare via cfg_q and pat_q.
// Reset loads the register defaults and an empty block at address zero; no clearing pass.
// A waiting result stalls the compare stage only when that stage also holds a match.
`timescale 1ns / 1ps
`include "wildcard_byte_pattern_scanner_defines.svh"
module wildcard_byte_pattern_scanner (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [7:0]                          data_byte,
	input  logic                                block_start,
	input  logic [wbps_pkg::ADDR_W-1:0]         block_address,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [wbps_pkg::ADDR_W-1:0]         match_address,
	input  logic                                cfg_write,
	input  logic [wbps_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wbps_pkg::CFG_DATA_W-1:0]     cfg_data
);

	wbps_pkg::cfg_t    cfg_q;
	wbps_pkg::window_t window_q;
	wbps_pkg::pos_t    pos_q;
	wbps_pkg::addr_t   base_q;
	wbps_pkg::pos_t    offset;
	wbps_pkg::addr_t   match_address_q;
	logic              valid_s1;
	logic              out_valid_q;
	logic              hit;
	logic              in_fire;
	logic              s1_adv;
	logic              out_load;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern <= '0;
			cfg_q.wild    <= '0;
			cfg_q.length  <= wbps_pkg::LEN_W'(1);
		end else if (cfg_write) begin
			unique case (wbps_pkg::cfg_reg_t'(cfg_index))
				wbps_pkg::REG_PATTERN_0: cfg_q.pattern[0] <= cfg_data;
				wbps_pkg::REG_PATTERN_1: cfg_q.pattern[1] <= cfg_data;
				wbps_pkg::REG_PATTERN_2: cfg_q.pattern[2] <= cfg_data;
				wbps_pkg::REG_PATTERN_3: cfg_q.pattern[3] <= cfg_data;
				wbps_pkg::REG_WILDCARD:  cfg_q.wild <= cfg_data[wbps_pkg::WILD_W-1:0];
				wbps_pkg::REG_LENGTH:    cfg_q.length <= cfg_data[wbps_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_fire  = in_valid && in_ready;
	assign s1_adv   = valid_s1 && (!hit || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_adv;
	assign out_load = s1_adv && hit;

	// Window shift line; stale bytes beyond the block are masked by the position check.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			window_q <= {window_q[wbps_pkg::PATTERN_MAX-2:0], data_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			base_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (in_fire) begin
				priority if (block_start) begin
					base_q <= block_address;
					pos_q  <= wbps_pkg::POS_W'(1);
				end else if (pos_q >= wbps_pkg::POS_W'(wbps_pkg::BLOCK_BYTES)) begin
					// Full block: roll into the next one.
					base_q <= base_q + wbps_pkg::ADDR_W'(wbps_pkg::BLOCK_BYTES);
					pos_q  <= wbps_pkg::POS_W'(1);
				end else begin
					pos_q <= pos_q + wbps_pkg::POS_W'(1);
				end
			end
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	wbps_match u_match (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.window (window_q),
		.pos    (pos_q),
		.hit    (hit),
		.offset (offset)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			match_address_q <= base_q + wbps_pkg::ADDR_W'(offset);
		end
	end

	assign out_valid     = out_valid_q;
	assign match_address = match_address_q;

	`WBPS_ASSERT_NOW(a_stall_cause, (!in_ready), (valid_s1 && hit && out_valid_q),
		"input stalled without a blocked match")
	`WBPS_ASSERT_NOW(a_load_src, out_load, (valid_s1 && hit), "result loaded without a match")
	`WBPS_ASSERT_NOW(a_pos_bound, 1'b1,
		(pos_q <= wbps_pkg::POS_W'(wbps_pkg::BLOCK_BYTES)), "block position overflow")
	`WBPS_ASSERT_NEXT(a_s1_hold, (valid_s1 && !s1_adv), valid_s1, "stalled match dropped")

endmodule
